/* src/assert_macros.svh */
// assertion macros shared by the regulator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define DMSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define DMSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DMSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/dmsr_pkg.sv */
// shared widths, constants, types and helper functions of the speed regulator
package dmsr_pkg;

  localparam int MOTORS = 2;
  localparam int MOT_W  = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  // field widths
  localparam int CNT_W = 11;
  localparam int TGT_W = 8;
  localparam int PWM_W = 10;
  localparam int REG_W = 10;
  localparam int DRV_W = 11;

  // datapath widths
  localparam int TC_W    = TGT_W;          // clamped target, +-100
  localparam int Q_W     = 8;              // count / 15, +-68
  localparam int MAG_W   = CNT_W + 1;      // count magnitude
  localparam int RECIP_W = 13;
  localparam int RECIP_SH = 16;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int TC2_W   = 14;             // target squared
  localparam int Q2_W    = 13;             // speed quotient squared
  localparam int CUBE_W  = 20;             // target cubed
  localparam int DIV_W   = 24;             // divider operand width
  localparam int DIVC_W  = $clog2(DIV_W + 1);
  localparam int CMP_W   = 18;             // scaled target and speed
  localparam int V_W     = 14;             // raw drive before limiting
  localparam int QV_W    = 12;             // useful quotient bits
  localparam int LIM_W   = 15;             // slew and clamp arithmetic

  // reciprocal of 15 for counts up to 1024
  localparam logic [RECIP_W-1:0] RECIP15 = RECIP_W'(4370);

  localparam logic signed [TGT_W-1:0] TGT_HI = TGT_W'(100);
  localparam logic signed [TGT_W-1:0] TGT_LO = -TGT_W'(100);

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DRIVE = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SLEW_STEP = 1'b1;
  localparam logic [REG_W-1:0] MAX_DRIVE_RST = REG_W'(600);
  localparam logic [REG_W-1:0] SLEW_STEP_RST = REG_W'(100);

  // decision handed from the tier logic to the limiter
  typedef struct packed {
    logic                    ratio;   // drive comes from the divider
    logic                    neg;     // ratio result is negated
    logic signed [V_W-1:0]   fixed;   // drive when no division is used
    logic [DIV_W-1:0]        num;
    logic [DIV_W-1:0]        den;
  } tier_t;

  function automatic logic signed [TC_W-1:0] clamp_target(input logic signed [TGT_W-1:0] tgt);
    logic signed [TC_W-1:0] r;
    if (tgt > TGT_HI)
      r = TGT_HI;
    else if (tgt < TGT_LO)
      r = TGT_LO;
    else
      r = tgt;
    return r;
  endfunction

  // count / 15 truncated toward zero
  function automatic logic signed [Q_W-1:0] div15(input logic signed [CNT_W-1:0] cnt);
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    qm;
    mag  = cnt[CNT_W-1] ? (MAG_W'(~cnt) + MAG_W'(1)) : MAG_W'(cnt);
    prod = PROD_W'(mag) * PROD_W'(RECIP15);
    qm   = prod[RECIP_SH +: Q_W];
    return cnt[CNT_W-1] ? Q_W'(-qm) : qm;
  endfunction

endpackage

/* src/dmsr_in_if.sv */
// input channel: one control tick per transaction
interface dmsr_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   enabled;
  logic signed [dmsr_pkg::CNT_W-1:0]      count_left;
  logic signed [dmsr_pkg::CNT_W-1:0]      count_right;
  logic signed [dmsr_pkg::TGT_W-1:0]      target_left;
  logic signed [dmsr_pkg::TGT_W-1:0]      target_right;

  modport source (
    output valid, enabled, count_left, count_right, target_left, target_right,
    input  ready
  );
  modport sink (
    input  valid, enabled, count_left, count_right, target_left, target_right,
    output ready
  );
endinterface

/* src/dmsr_out_if.sv */
// result channel: sign/magnitude pwm for both motors per transaction
interface dmsr_out_if;
  logic                          valid;
  logic                          ready;
  logic [dmsr_pkg::PWM_W-1:0]    pwm_left;
  logic                          reverse_left;
  logic [dmsr_pkg::PWM_W-1:0]    pwm_right;
  logic                          reverse_right;

  modport source (
    output valid, pwm_left, reverse_left, pwm_right, reverse_right,
    input  ready
  );
  modport sink (
    input  valid, pwm_left, reverse_left, pwm_right, reverse_right,
    output ready
  );
endinterface

/* src/dual_motor_speed_regulator.sv */
// top level of the dual motor speed regulator
// Each input transaction is one control tick carrying an encoder count and a
// percent speed target per motor. A tick with enabled low is taken and gives
// no result. An enabled tick runs both motors one after the other through a
// shared datapath: target clamp and count/15, squares, cube, tier decision, a
// bit-serial divider that yields one quotient bit per cycle, and slew limit
// plus clamp. The result is loaded into the output register once the last
// motor is done, and the next tick can be taken only after that load.
// Input ready is high only between ticks; the output register holds one
// finished result while the next tick is already accepted. The previous drive
// of each motor is kept in flip-flops and cleared by reset. max_drive and
// slew_step sit on an apb-style port at byte addresses 0 and 4; change them
// only while no tick is in flight.

`include "assert_macros.svh"

module dual_motor_speed_regulator (
  input  logic                              clk,
  input  logic                              rst_n,
  dmsr_in_if.sink                           in_ch,
  dmsr_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dmsr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [dmsr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [dmsr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  localparam int MOTORS = dmsr_pkg::MOTORS;
  localparam int MOT_W  = dmsr_pkg::MOT_W;
  localparam int CNT_W  = dmsr_pkg::CNT_W;
  localparam int TGT_W  = dmsr_pkg::TGT_W;
  localparam int DRV_W  = dmsr_pkg::DRV_W;
  localparam int PWM_W  = dmsr_pkg::PWM_W;
  localparam int REG_W  = dmsr_pkg::REG_W;
  localparam int TC_W   = dmsr_pkg::TC_W;
  localparam int Q_W    = dmsr_pkg::Q_W;
  localparam int TC2_W  = dmsr_pkg::TC2_W;
  localparam int Q2_W   = dmsr_pkg::Q2_W;
  localparam int CUBE_W = dmsr_pkg::CUBE_W;
  localparam int DIV_W  = dmsr_pkg::DIV_W;

  localparam logic [MOT_W-1:0] LAST_MOT = MOT_W'(MOTORS - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;  // clamp target, count / 15
  localparam logic [2:0] ST_MUL    = 3'd2;  // squares
  localparam logic [2:0] ST_CUBE   = 3'd3;  // target cubed
  localparam logic [2:0] ST_DECIDE = 3'd4;  // tier choice, divider start
  localparam logic [2:0] ST_DIV    = 3'd5;  // serial divide
  localparam logic [2:0] ST_LIMIT  = 3'd6;  // slew, clamp, store drive
  localparam logic [2:0] ST_FINISH = 3'd7;  // hand result to output register

  function automatic logic [PWM_W-1:0] drive_mag(input logic signed [DRV_W-1:0] d);
    logic [DRV_W-1:0] m;
    m = d[DRV_W-1] ? DRV_W'(-d) : DRV_W'(d);
    return m[PWM_W-1:0];
  endfunction

  logic [2:0]                    state_r;
  logic [2:0]                    state_nxt;
  logic [MOT_W-1:0]              mot_r;
  logic [MOT_W-1:0]              mot_nxt;

  // latched tick
  logic [MOTORS-1:0][CNT_W-1:0]  cnt_r;
  logic [MOTORS-1:0][TGT_W-1:0]  tgt_r;

  // per-motor working registers
  logic signed [TC_W-1:0]        tc_r;
  logic signed [Q_W-1:0]         q_r;
  logic [TC2_W-1:0]              tc2_r;
  logic [Q2_W-1:0]               q2_r;
  logic [CUBE_W-1:0]             cube_r;
  logic [TC_W-1:0]               abs_tc;
  logic [Q_W-1:0]                abs_q;
  dmsr_pkg::tier_t               tier_c;
  dmsr_pkg::tier_t               tier_r;

  // previous drive per motor
  logic [MOTORS-1:0][DRV_W-1:0]  last_r;
  logic signed [DRV_W-1:0]       last_sel;
  logic signed [DRV_W-1:0]       drive_c;

  logic [REG_W-1:0]              max_drive_r;
  logic [REG_W-1:0]              slew_step_r;

  logic                          out_valid_r;
  logic [PWM_W-1:0]              pwm_left_r;
  logic                          reverse_left_r;
  logic [PWM_W-1:0]              pwm_right_r;
  logic                          reverse_right_r;

  logic                          in_acc;
  logic                          load_out;
  logic                          div_start;
  logic                          div_busy;
  logic                          div_done;
  logic [DIV_W-1:0]              div_quot;
  logic                          cfg_wr;
  logic [dmsr_pkg::REG_IDX_W-1:0] reg_idx;

  // ---------------------------------------------------------------- handshakes
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign load_out    = (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pwm_left      = pwm_left_r;
  assign out_ch.reverse_left  = reverse_left_r;
  assign out_ch.pwm_right     = pwm_right_r;
  assign out_ch.reverse_right = reverse_right_r;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[dmsr_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      dmsr_pkg::REG_MAX_DRIVE: prdata = dmsr_pkg::CFG_DATA_W'(max_drive_r);
      dmsr_pkg::REG_SLEW_STEP: prdata = dmsr_pkg::CFG_DATA_W'(slew_step_r);
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    mot_nxt   = mot_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // a disabled tick is dropped right here
        if (in_acc && in_ch.enabled) begin
          state_nxt = ST_PREP;
          mot_nxt   = '0;
        end
      end
      ST_PREP:   state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_CUBE;
      ST_CUBE:   state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done)
          state_nxt = ST_LIMIT;
      end
      ST_LIMIT: begin
        if (mot_r == LAST_MOT) begin
          state_nxt = ST_FINISH;
        end else begin
          mot_nxt   = mot_r + MOT_W'(1);
          state_nxt = ST_PREP;
        end
      end
      ST_FINISH: begin
        if (load_out)
          state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- datapath
  assign abs_tc   = tc_r[TC_W-1] ? TC_W'(-tc_r) : TC_W'(tc_r);
  assign abs_q    = q_r[Q_W-1] ? Q_W'(-q_r) : Q_W'(q_r);
  assign last_sel = last_r[mot_r];

  dmsr_tier u_tier (
    .tc        (tc_r),
    .q         (q_r),
    .tc2       (tc2_r),
    .q2        (q2_r),
    .cube      (cube_r),
    .last      (last_sel),
    .max_drive (max_drive_r),
    .tier      (tier_c)
  );

  dmsr_serdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (tier_c.num),
    .den   (tier_c.den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  dmsr_limit u_limit (
    .tier      (tier_r),
    .quot      (div_quot),
    .last      (last_sel),
    .max_drive (max_drive_r),
    .slew_step (slew_step_r),
    .drive     (drive_c)
  );

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cnt_r <= {in_ch.count_right, in_ch.count_left};
      tgt_r <= {in_ch.target_right, in_ch.target_left};
    end
    if (state_r == ST_PREP) begin
      tc_r <= dmsr_pkg::clamp_target(tgt_r[mot_r]);
      q_r  <= dmsr_pkg::div15(cnt_r[mot_r]);
    end
    if (state_r == ST_MUL) begin
      tc2_r <= TC2_W'(abs_tc) * TC2_W'(abs_tc);
      q2_r  <= Q2_W'(abs_q) * Q2_W'(abs_q);
    end
    if (state_r == ST_CUBE)
      cube_r <= CUBE_W'(tc2_r) * CUBE_W'(abs_tc);
    if (state_r == ST_DECIDE)
      tier_r <= tier_c;
    if (load_out) begin
      pwm_left_r      <= drive_mag(last_r[0]);
      reverse_left_r  <= last_r[0][DRV_W-1];
      pwm_right_r     <= drive_mag(last_r[1]);
      reverse_right_r <= last_r[1][DRV_W-1];
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mot_r       <= '0;
      last_r      <= '0;
      max_drive_r <= dmsr_pkg::MAX_DRIVE_RST;
      slew_step_r <= dmsr_pkg::SLEW_STEP_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mot_r   <= mot_nxt;
      if (state_r == ST_LIMIT)
        last_r[mot_r] <= drive_c;
      if (cfg_wr && (reg_idx == dmsr_pkg::REG_MAX_DRIVE))
        max_drive_r <= pwdata[REG_W-1:0];
      if (cfg_wr && (reg_idx == dmsr_pkg::REG_SLEW_STEP))
        slew_step_r <= pwdata[REG_W-1:0];
      if (load_out)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- assertions
  // the divider runs exactly while the sequencer waits on it
  `DMSR_ASSERT(a_div_in_step, (state_r == ST_DIV) == div_busy, "divider out of step with sequencer")
  // an enabled tick always starts the per-motor work
  `DMSR_ASSERT_NXT(a_tick_start, in_acc && in_ch.enabled, state_r == ST_PREP, "enabled tick not started")
  // a disabled tick leaves the stored drives alone and keeps the block idle
  `DMSR_ASSERT_NXT(a_skip_tick, in_acc && !in_ch.enabled, $stable(last_r) && (state_r == ST_IDLE), "disabled tick changed state")
  // a result appears only at the end of a tick
  `DMSR_ASSERT_IMP(a_out_source, $rose(out_valid_r), $past(state_r) == ST_FINISH, "result without finished tick")
endmodule

/* src/dmsr_serdiv.sv */
// bit-serial restoring divider, one quotient bit per cycle
module dmsr_serdiv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dmsr_pkg::DIV_W-1:0] num,
  input  logic [dmsr_pkg::DIV_W-1:0] den,
  output logic                       busy,
  output logic                       done,
  output logic [dmsr_pkg::DIV_W-1:0] quot
);
  localparam int DIV_W  = dmsr_pkg::DIV_W;
  localparam int DIVC_W = dmsr_pkg::DIVC_W;

  logic [DIVC_W-1:0] cnt_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DIV_W-1:0]  den_r;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    trial;
  logic              fits;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    trial   = shifted - {1'b0, den_r};
    fits    = !trial[DIV_W];
  end

  assign busy = (cnt_r != '0);
  assign done = (cnt_r == DIVC_W'(1));
  assign quot = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIVC_W'(DIV_W);
    end else if (busy) begin
      cnt_r <= cnt_r - DIVC_W'(1);
    end
  end

  // dividend shifts out of the top of quo_r while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy) begin
      rem_r <= fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end
endmodule

/* src/dmsr_tier.sv */
// three-tier drive rule: picks a direct drive value or divider operands
module dmsr_tier (
  input  logic signed [dmsr_pkg::TC_W-1:0]  tc,
  input  logic signed [dmsr_pkg::Q_W-1:0]   q,
  input  logic [dmsr_pkg::TC2_W-1:0]        tc2,
  input  logic [dmsr_pkg::Q2_W-1:0]         q2,
  input  logic [dmsr_pkg::CUBE_W-1:0]       cube,
  input  logic signed [dmsr_pkg::DRV_W-1:0] last,
  input  logic [dmsr_pkg::REG_W-1:0]        max_drive,
  output dmsr_pkg::tier_t                   tier
);
  localparam int CMP_W = dmsr_pkg::CMP_W;
  localparam int V_W   = dmsr_pkg::V_W;
  localparam int DIV_W = dmsr_pkg::DIV_W;
  localparam int TC_W  = dmsr_pkg::TC_W;
  localparam int Q_W   = dmsr_pkg::Q_W;

  // speeds in tenths of a percent: target * 10, (count / 15) * 600
  localparam logic signed [CMP_W-1:0] T_SCALE = CMP_W'(10);
  localparam logic signed [CMP_W-1:0] S_SCALE = CMP_W'(600);
  localparam logic signed [CMP_W-1:0] LARGE_T = CMP_W'(80);
  localparam logic signed [CMP_W-1:0] BAND_L  = CMP_W'(40);
  localparam logic signed [CMP_W-1:0] BAND_M  = CMP_W'(15);
  localparam logic signed [CMP_W-1:0] BAND_S  = CMP_W'(3);

  // 1.1 gain with the x10 scalings folded out of numerator and denominator
  localparam logic signed [V_W-1:0] OFF_GAIN  = V_W'(11);
  localparam logic signed [V_W-1:0] OFF_BIAS  = V_W'(100);
  localparam logic [DIV_W-1:0]      RATIO_GAIN = DIV_W'(11);
  localparam logic [DIV_W-1:0]      CUBE_DEN   = DIV_W'(3600);
  localparam logic [DIV_W-1:0]      SQ_DEN     = DIV_W'(60);

  logic signed [CMP_W-1:0] t_v;
  logic signed [CMP_W-1:0] s_v;
  logic signed [CMP_W-1:0] diff;
  logic                    big_err;
  logic                    mid_err;
  logic                    tc_zero;
  logic                    opposite;
  logic [Q_W-1:0]          abs_q;
  logic signed [V_W-1:0]   mx_v;
  logic signed [V_W-1:0]   off_v;
  logic signed [V_W-1:0]   last_v;

  always_comb begin
    t_v      = CMP_W'(tc) * T_SCALE;
    s_v      = CMP_W'(q) * S_SCALE;
    diff     = t_v - s_v;
    big_err  = ((t_v > LARGE_T) || (t_v < -LARGE_T)) && ((diff < -BAND_L) || (diff > BAND_L));
    mid_err  = (diff < -BAND_M) || (diff > BAND_M);
    tc_zero  = (tc == '0);
    // target and speed disagree in sign, or the motor stands still
    opposite = !tc_zero && ((q == '0) || (tc[TC_W-1] != q[Q_W-1]));
    abs_q    = q[Q_W-1] ? Q_W'(-q) : Q_W'(q);
    mx_v     = V_W'(max_drive);
    off_v    = V_W'(tc) * OFF_GAIN + OFF_BIAS;
    last_v   = V_W'(last);

    tier.ratio = 1'b0;
    tier.neg   = tc[TC_W-1];
    tier.fixed = '0;
    tier.num   = '0;
    tier.den   = '0;

    if (big_err) begin
      if (opposite) begin
        tier.fixed = tc[TC_W-1] ? -mx_v : mx_v;
      end else begin
        tier.ratio = 1'b1;
        tier.num   = DIV_W'(cube) * RATIO_GAIN;
        tier.den   = DIV_W'(q2) * CUBE_DEN;
      end
    end else if (mid_err) begin
      if (opposite) begin
        tier.fixed = off_v;
      end else if (!tc_zero) begin
        tier.ratio = 1'b1;
        tier.num   = DIV_W'(tc2) * RATIO_GAIN;
        tier.den   = DIV_W'(abs_q) * SQ_DEN;
      end
    end else begin
      // small error: nudge by one count
      if (tc_zero)
        tier.fixed = '0;
      else if (diff < -BAND_S)
        tier.fixed = last_v + V_W'(1);
      else if (diff > BAND_S)
        tier.fixed = last_v - V_W'(1);
      else
        tier.fixed = last_v;
    end
  end
endmodule

/* src/dmsr_limit.sv */
// slew limit against the previous drive, then clamp to +-max_drive
module dmsr_limit (
  input  dmsr_pkg::tier_t                   tier,
  input  logic [dmsr_pkg::DIV_W-1:0]        quot,
  input  logic signed [dmsr_pkg::DRV_W-1:0] last,
  input  logic [dmsr_pkg::REG_W-1:0]        max_drive,
  input  logic [dmsr_pkg::REG_W-1:0]        slew_step,
  output logic signed [dmsr_pkg::DRV_W-1:0] drive
);
  localparam int LIM_W = dmsr_pkg::LIM_W;
  localparam int QV_W  = dmsr_pkg::QV_W;
  localparam int DRV_W = dmsr_pkg::DRV_W;

  logic signed [LIM_W-1:0] q_v;
  logic signed [LIM_W-1:0] v_v;
  logic signed [LIM_W-1:0] last_v;
  logic signed [LIM_W-1:0] sl_v;
  logic signed [LIM_W-1:0] mx_v;
  logic signed [LIM_W-1:0] step_v;
  logic signed [LIM_W-1:0] slew_v;
  logic signed [LIM_W-1:0] clamp_v;

  always_comb begin
    q_v    = LIM_W'(quot[QV_W-1:0]);
    v_v    = tier.ratio ? (tier.neg ? -q_v : q_v) : LIM_W'(tier.fixed);
    last_v = LIM_W'(last);
    sl_v   = LIM_W'(slew_step);
    mx_v   = LIM_W'(max_drive);
    step_v = v_v - last_v;

    if (step_v > sl_v)
      slew_v = last_v + sl_v;
    else if (step_v < -sl_v)
      slew_v = last_v - sl_v;
    else
      slew_v = v_v;

    if (slew_v > mx_v)
      clamp_v = mx_v;
    else if (slew_v < -mx_v)
      clamp_v = -mx_v;
    else
      clamp_v = slew_v;

    drive = DRV_W'(clamp_v);
  end
endmodule
